// ===== rtl/core/billboard_spacing_max_revenue_assert.svh =====
// assertion macros for the billboard revenue block
`ifndef BILLBOARD_SPACING_MAX_REVENUE_ASSERT_SVH
`define BILLBOARD_SPACING_MAX_REVENUE_ASSERT_SVH

`ifndef SYNTHESIS

`define BBSMR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

`define BBSMR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`else

`define BBSMR_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`define BBSMR_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/core/bbsmr_pkg.sv =====
// shared constants and types for the billboard revenue block
package bbsmr_pkg;

   localparam int HISTORY_DEPTH = 1024;
   localparam int PTR_W         = $clog2(HISTORY_DEPTH);
   localparam int GAP_W         = 10;
   localparam int REV_W         = 16;
   localparam int SUM_W         = 32;
   localparam int CNT_W         = 11;

   typedef logic [PTR_W-1:0] ptr_type;
   typedef logic [GAP_W-1:0] gap_type;
   typedef logic [REV_W-1:0] rev_type;
   typedef logic [SUM_W-1:0] sum_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam gap_type GAP_RESET = gap_type'(5);
   localparam cnt_type CNT_MAX   = '1;

endpackage

// ===== rtl/core/billboard_spacing_max_revenue.sv =====
// top level of the billboard revenue block
//
// one request word per road mile, in order from mile 1: req_tuser is set when
// a billboard stands at the mile, req_tdata carries its revenue, req_tlast
// marks the last mile of the road. for every request one response word comes
// back in order: rsp_tdata is the best total revenue up to that mile with any
// two chosen boards more than min_gap miles apart, saturating at all ones,
// and rsp_tlast copies the request's tlast. the next word after a tlast
// starts a new road.
// min_gap is written through csr_valid/csr_data, always ready; the user must
// write it only while the block is idle, which the block does not enforce.
// it resets to 5. throughput is one mile per cycle while the receiver keeps
// up: the lookback read of the history ram is issued when the request is
// taken, and the best value is folded in one compute stage the next cycle
// and loaded from there into the response register. when the receiver
// stalls, the response register and the compute stage hold and req_tready
// drops once both are full. reset is synchronous; the history ram needs no
// clearing pass, the empty mile-0 slot is tracked by a single flag.
`include "billboard_spacing_max_revenue_assert.svh"

module billboard_spacing_max_revenue
   import bbsmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [9:0]  csr_data,    // min_gap
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // revenue
   input  logic        req_tuser,   // board_here
   input  logic        req_tlast,   // last_mile
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // best_revenue
   output logic        rsp_tlast    // final_res
);

   gap_type min_gap_ff;

   ptr_type ptr_ff, ptr_in, ptr_next, back, rd_addr;
   cnt_type cnt_ff, cnt_in;
   logic    slot0_ff, slot0_in;

   logic    s1_valid_ff;
   rev_type s1_rev_ff;
   logic    s1_here_ff, s1_last_ff, s1_look_ff, s1_fwd_ff, s1_zero_ff;
   ptr_type s1_slot_ff;
   sum_type prev_best_ff;

   logic    rsp_valid_ff, rsp_last_ff;
   sum_type rsp_best_ff;

   logic    req_fire, s1_adv;
   sum_type rd_data, look, cand, base, best;
   logic [SUM_W:0] sum_wide;

   assign csr_ready = 1'b1;

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_fire   = req_tvalid && req_tready;

   // lookback slot and road bookkeeping on the request side
   assign back     = ptr_type'(min_gap_ff);
   assign rd_addr  = ptr_ff - back;
   assign ptr_next = ptr_ff + ptr_type'(1);

   always_comb begin
      ptr_in   = ptr_ff;
      cnt_in   = cnt_ff;
      slot0_in = slot0_ff;
      if (req_fire) begin
         if (req_tlast) begin
            ptr_in   = '0;
            cnt_in   = '0;
            slot0_in = 1'b0;
         end else begin
            ptr_in = ptr_next;
            if (cnt_ff != CNT_MAX) begin
               cnt_in = cnt_ff + cnt_type'(1);
            end
            if (ptr_next == '0) begin
               slot0_in = 1'b1;
            end
         end
      end
   end

   bbsmr_ram #(
      .DEPTH (HISTORY_DEPTH),
      .WIDTH (SUM_W)
   ) u_hist (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_slot_ff),
      .wr_data (best),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // compute stage
   always_comb begin
      if (s1_fwd_ff) begin
         look = prev_best_ff;
      end else if (s1_zero_ff) begin
         look = '0;
      end else begin
         look = rd_data;
      end
      sum_wide = {1'b0, look} + {{(SUM_W+1-REV_W){1'b0}}, s1_rev_ff};
      cand     = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
      base     = s1_look_ff ? cand : {{(SUM_W-REV_W){1'b0}}, s1_rev_ff};
      best     = (s1_here_ff && (base > prev_best_ff)) ? base : prev_best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_gap_ff   <= GAP_RESET;
         ptr_ff       <= '0;
         cnt_ff       <= '0;
         slot0_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         prev_best_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            min_gap_ff <= csr_data;
         end
         ptr_ff   <= ptr_in;
         cnt_ff   <= cnt_in;
         slot0_ff <= slot0_in;
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            prev_best_ff <= s1_last_ff ? '0 : best;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_fire) begin
         s1_rev_ff  <= req_tdata;
         s1_here_ff <= req_tuser;
         s1_last_ff <= req_tlast;
         s1_look_ff <= cnt_ff >= {1'b0, min_gap_ff};
         s1_fwd_ff  <= back == '0;
         s1_zero_ff <= (rd_addr == '0) && !slot0_ff;
         s1_slot_ff <= ptr_next;
      end
      if (s1_adv) begin
         rsp_best_ff <= best;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_best_ff;
   assign rsp_tlast  = rsp_last_ff;

   `BBSMR_ASSERT_IMPLIES(a_no_overrun, clock, reset, req_fire, !s1_valid_ff || s1_adv)
   `BBSMR_ASSERT_NEXT(a_adv_loads_rsp, clock, reset, s1_adv, rsp_valid_ff)
   `BBSMR_ASSERT_NEXT(a_stage_holds, clock, reset, s1_valid_ff && !s1_adv, s1_valid_ff)
   `BBSMR_ASSERT_NEXT(a_road_restart, clock, reset, req_fire && req_tlast,
      (cnt_ff == '0) && (ptr_ff == '0) && !slot0_ff)

endmodule

// ===== rtl/core/bbsmr_ram.sv =====
// simple dual port ram, one write port, one registered read port
module bbsmr_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== test/bbsmr_revenue_checker.sv =====
// checker for the billboard revenue block: predicts each mile's best revenue and compares
module bbsmr_revenue_checker
   import bbsmr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [9:0]  csr_data,    // min_gap
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // revenue
   input  logic        req_tuser,   // board_here
   input  logic        req_tlast,   // last_mile
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,   // best_revenue
   input  logic        rsp_tlast,   // final_res
   output int          fail_count,
   output int          pending_count
);

   typedef struct packed {
      sum_type best;
      logic    last;
   } mile_best_type;

   sum_type       road_best [HISTORY_DEPTH];
   ptr_type       ring_ptr;
   sum_type       prev_best;
   cnt_type       miles_done;
   gap_type       gap;
   mile_best_type best_due [$];
   int            fails = 0;

   task automatic note_fail(input string msg);
      if (fails < 10) $display("mismatch: %s", msg);
      fails++;
   endtask

   always @(posedge clock) begin
      mile_best_type  due;
      logic [SUM_W:0] cand;
      sum_type        best;
      ptr_type        slot;
      if (reset) begin
         for (int i = 0; i < HISTORY_DEPTH; i++) road_best[i] = '0;
         ring_ptr   = '0;
         prev_best  = '0;
         miles_done = '0;
         gap        = GAP_RESET;
         best_due.delete();
      end else begin
         if (csr_valid && csr_ready) gap = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (best_due.size() == 0) begin
               note_fail($sformatf("unexpected word, best %h last %b", rsp_tdata, rsp_tlast));
            end else begin
               due = best_due.pop_front();
               if (rsp_tdata !== due.best)
                  note_fail($sformatf("best_revenue expected %h, got %h", due.best, rsp_tdata));
               if (rsp_tlast !== due.last)
                  note_fail($sformatf("final_res expected %b, got %b", due.last, rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            best = prev_best;
            if (req_tuser) begin
               if (miles_done < {1'b0, gap}) begin
                  if (sum_type'(req_tdata) > best) best = sum_type'(req_tdata);
               end else begin
                  // slot of mile m - min_gap - 1
                  slot = ring_ptr - ptr_type'(gap);
                  cand = {1'b0, road_best[slot]} + (SUM_W+1)'(req_tdata);
                  if (cand[SUM_W]) cand[SUM_W-1:0] = '1;
                  if (cand[SUM_W-1:0] > best) best = cand[SUM_W-1:0];
               end
            end
            ring_ptr = ring_ptr + ptr_type'(1);
            road_best[ring_ptr] = best;
            prev_best = best;
            if (miles_done != CNT_MAX) miles_done = miles_done + cnt_type'(1);
            best_due.push_back('{best: best, last: req_tlast});
            if (req_tlast) begin
               ring_ptr    = '0;
               prev_best   = '0;
               miles_done  = '0;
               road_best[0] = '0;
            end
         end
      end
      fail_count    <= fails;
      pending_count <= best_due.size();
   end

endmodule

// ===== test/tb_billboard_spacing_max_revenue.sv =====
// testbench top for the billboard revenue block: stimulus, idling, watchdog and verdict
module tb_billboard_spacing_max_revenue;
   import bbsmr_pkg::*;

   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [9:0]  csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;

   int      fail_count;
   int      pending_count;
   int      snd_idle = 0;
   int      rcv_idle = 0;
   int      miles_sent = 0;
   int      roads_sent = 0;
   int      gap_writes = 0;
   int      idle_cycles = 0;
   gap_type cur_gap = GAP_RESET;

   initial begin
      forever #5 clock = ~clock;
   end

   billboard_spacing_max_revenue DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   bbsmr_revenue_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rcv_idle);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d cycles without a word, %0d results pending",
                  idle_cycles, pending_count);
         $display("tb_billboard_spacing_max_revenue NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic rev_type pick_rev();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return rev_type'($urandom_range(15));
         default: return rev_type'($urandom);
      endcase
   endfunction

   task automatic send_mile(input logic here, input rev_type rev, input logic last);
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= here;
      req_tdata  <= rev;
      req_tlast  <= last;
      do @(posedge clock); while (req_tready !== 1'b1);
      miles_sent++;
      if (last) roads_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic write_gap(input gap_type g);
      drain();
      csr_valid <= 1'b1;
      csr_data  <= g;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      cur_gap = g;
      gap_writes++;
   endtask

   initial begin
      int      road_left;
      int      board_pct;
      int      phase_left;
      int      next_cfg;
      gap_type g;
      road_left = 0;
      board_pct = 50;
      snd_idle  = 38;
      rcv_idle  = 66;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset gap of 5: both sides of the boundary, ignored revenue, extremes
      send_mile(1'b1, 16'hFFFF, 1'b0);
      send_mile(1'b0, 16'hFFFF, 1'b0);
      send_mile(1'b1, 16'h0000, 1'b0);
      send_mile(1'b1, 16'h1234, 1'b0);
      send_mile(1'b1, 16'h8000, 1'b0);
      send_mile(1'b1, 16'hFFFF, 1'b0);
      send_mile(1'b1, 16'hFFFF, 1'b0);
      send_mile(1'b1, 16'h0007, 1'b1);
      // single-mile road
      send_mile(1'b1, 16'h5555, 1'b1);
      // gap change in the middle of a road
      send_mile(1'b0, 16'h0000, 1'b0);
      send_mile(1'b1, 16'hAAAA, 1'b0);
      write_gap(10'd0);
      send_mile(1'b1, 16'hFFFF, 1'b0);
      send_mile(1'b1, 16'hFFFF, 1'b0);
      send_mile(1'b0, 16'hFFFF, 1'b1);
      write_gap(10'd1023);
      send_mile(1'b1, 16'h0100, 1'b0);
      send_mile(1'b1, 16'h0200, 1'b0);
      send_mile(1'b0, 16'h0000, 1'b1);
      write_gap(10'd1);
      send_mile(1'b1, 16'hFFFF, 1'b0);
      send_mile(1'b1, 16'hFFFF, 1'b0);
      send_mile(1'b1, 16'h0001, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               snd_idle = 38;
               rcv_idle = 66;
            end
            1: begin
               snd_idle = 66;
               rcv_idle = 38;
            end
            default: begin
               snd_idle = 0;
               rcv_idle = 0;
            end
         endcase
         phase_left = 210;
         next_cfg   = 0;
         while (phase_left > 0) begin
            if (next_cfg <= 0) begin
               case ($urandom_range(9))
                  0: g = 10'd0;
                  1: g = 10'd1023;
                  2: g = gap_type'($urandom_range(1023));
                  3: g = gap_type'($urandom_range(80, 13));
                  default: g = gap_type'($urandom_range(12));
               endcase
               write_gap(g);
               next_cfg = $urandom_range(160, 60);
            end
            if (road_left == 0) begin
               road_left = (cur_gap <= 80) ? $urandom_range(cur_gap + 30, 1)
                                           : $urandom_range(60, 1);
               board_pct = $urandom_range(100, 10);
            end else if ($urandom_range(199) == 0) begin
               drain();
            end
            send_mile($urandom_range(99) < board_pct, pick_rev(), road_left == 1);
            road_left--;
            phase_left--;
            next_cfg--;
         end
      end

      // road longer than the ring at the widest gap, lookback wraps the history
      write_gap(10'd1023);
      for (int i = 1; i <= 1100; i++)
         send_mile(1'(($urandom_range(1))), pick_rev(), i == 1100);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("ran %0d miles on %0d roads over %0d gap writes, gaps from 0 to 1023",
               miles_sent, roads_sent, gap_writes);
      $display("with gap changes mid road and an 1100-mile road wrapping the ring at gap 1023");
      if (fail_count == 0) begin
         $display("tb_billboard_spacing_max_revenue OK");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("tb_billboard_spacing_max_revenue NOT OK");
      end
      $finish;
   end

endmodule

// ===== billboard_spacing_max_revenue.f =====
+incdir+rtl/core
rtl/core/bbsmr_pkg.sv
rtl/core/bbsmr_ram.sv
rtl/core/billboard_spacing_max_revenue.sv
test/bbsmr_revenue_checker.sv
test/tb_billboard_spacing_max_revenue.sv
